### rtl/core/lfu_pkg.sv
package lfu_pkg;
	localparam int ENTRIES = 16;
	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int CAP_W = 5;
	localparam int TTL_W = 31;
	localparam int UCNT_W = 16;
	localparam logic [UCNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic [1:0] {
		FN_GET  = 2'd0,
		FN_PUT  = 2'd1,
		FN_DUMP = 2'd2,
		FN_NONE = 2'd3
	} func_t;

	typedef enum logic {
		CFG_CAP = 1'b0,
		CFG_TTL = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_ACT,
		ST_DSCAN,
		ST_DOUT,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [31:0] age;
		logic        expired;
		logic        evict_better;
		logic        dump_better;
	} cmp_res_t;
endpackage

### rtl/core/lfu_cmp.sv
module lfu_cmp import lfu_pkg::*; (
	input  logic [31:0]       time_now,
	input  logic [31:0]       last_use,
	input  logic [UCNT_W-1:0] count,
	input  logic [TTL_W-1:0]  ttl,
	input  logic              best_ok,
	input  logic [UCNT_W-1:0] best_count,
	input  logic [31:0]       best_age,
	output cmp_res_t          res
);
	logic [31:0] age;

	always_comb begin
		age = time_now - last_use;
		res.age = age;
		res.expired = age > {1'b0, ttl};
		// least count first, oldest use among equal counts
		res.evict_better = !best_ok || (count < best_count) ||
			((count == best_count) && (age > best_age));
		res.dump_better = !best_ok || (age > best_age);
	end
endmodule

### rtl/core/lfu_cache_with_ttl_top.sv
// Get and put: accept in idle, a scan over all ENTRIES entries, then one action state;
// a get result then waits in the output register until transferred.
// Dump: each result takes a scan of all entries, a pick state and an output state.
// Throughput: one item at a time; the shared entry compare unit is the limit.
// Reset (arst_n low): all entries invalid, time zero, capacity 16, ttl 1000.
module lfu_cache_with_ttl_top import lfu_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         func,
	input  logic signed [31:0] key,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               hit,
	output logic signed [31:0] data,
	output logic               last,
	output logic               empty_res,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [TTL_W-1:0]   cfg_data
);
	state_t state_q, state_d;

	logic [ENTRIES-1:0] valid_q, done_q;
	logic [31:0]        key_q [ENTRIES];
	logic [31:0]        val_q [ENTRIES];
	logic [UCNT_W-1:0]  cnt_q [ENTRIES];
	logic [31:0]        use_q [ENTRIES];

	logic [31:0]       time_q;
	logic [CAP_W-1:0]  cap_q;
	logic [TTL_W-1:0]  ttl_q;
	logic [IDX_W-1:0]  idx_q;
	func_t             func_q;
	logic [31:0]       key_in_q, val_in_q;
	logic              match_ok_q, free_ok_q, best_ok_q;
	logic [IDX_W-1:0]  match_idx_q, free_idx_q, best_idx_q, slot;
	logic [UCNT_W-1:0] best_cnt_q;
	logic [31:0]       best_age_q;
	logic [CNT_W-1:0]  live_q;
	logic              hit_q, last_q, empty_q;
	logic [31:0]       data_q;

	cmp_res_t         cr;
	logic             scan_end, live_now, evict, victim_clr, in_xfer, out_xfer;
	logic [CAP_W-1:0] cap_eff;

	lfu_cmp u_cmp (
		.time_now  (time_q),
		.last_use  (use_q[idx_q]),
		.count     (cnt_q[idx_q]),
		.ttl       (ttl_q),
		.best_ok   (best_ok_q),
		.best_count(best_cnt_q),
		.best_age  (best_age_q),
		.res       (cr)
	);

	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid && !out_stall;
	assign scan_end = idx_q == IDX_W'(ENTRIES - 1);
	assign live_now = valid_q[idx_q] && !cr.expired;
	assign cap_eff  = (32'(cap_q) > 32'(ENTRIES)) ? CAP_W'(ENTRIES) : cap_q;
	assign evict    = (32'(live_q) >= 32'(cap_eff)) && best_ok_q;
	assign slot     = (evict && (!free_ok_q || best_idx_q < free_idx_q)) ? best_idx_q
		: free_idx_q;
	// eviction into another slot clears the victim in the same write as the new key
	assign victim_clr = evict && (slot != best_idx_q);

	assign hit       = hit_q;
	assign data      = data_q;
	assign last      = last_q;
	assign empty_res = empty_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					unique case (func_t'(func))
						FN_GET, FN_PUT: state_d = ST_SCAN;
						FN_DUMP:        state_d = ST_DSCAN;
						default:        state_d = ST_IDLE;
					endcase
				end
			end
			ST_SCAN:  if (scan_end) state_d = ST_ACT;
			ST_ACT:   state_d = (func_q == FN_GET) ? ST_OUT : ST_IDLE;
			ST_DSCAN: if (scan_end) state_d = ST_DOUT;
			ST_DOUT:  state_d = ST_OUT;
			ST_OUT:   if (out_xfer) state_d = last_q ? ST_IDLE : ST_DSCAN;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = state_q != ST_IDLE;
		out_valid = state_q == ST_OUT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
			done_q  <= '0;
			time_q  <= '0;
			cap_q   <= CAP_W'(16);
			ttl_q   <= TTL_W'(1000);
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_CAP: cap_q <= cfg_data[CAP_W-1:0];
					CFG_TTL: ttl_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					idx_q  <= '0;
					done_q <= '0;
				end
				ST_SCAN: begin
					idx_q <= idx_q + 1'b1;
					// drop expired entries as the scan passes them
					if (valid_q[idx_q] && cr.expired) valid_q[idx_q] <= 1'b0;
				end
				ST_ACT: begin
					time_q <= time_q + 1'b1;
					if (func_q == FN_GET) begin
						if (match_ok_q) begin
							if (cnt_q[match_idx_q] != COUNT_MAX)
								cnt_q[match_idx_q] <= cnt_q[match_idx_q] + 1'b1;
							use_q[match_idx_q] <= time_q;
						end
					end else if (cap_eff != '0) begin
						if (match_ok_q) begin
							val_q[match_idx_q] <= val_in_q;
							if (cnt_q[match_idx_q] != COUNT_MAX)
								cnt_q[match_idx_q] <= cnt_q[match_idx_q] + 1'b1;
							use_q[match_idx_q] <= time_q;
						end else if (evict || free_ok_q) begin
							valid_q <= (valid_q | (ENTRIES'(1) << slot)) &
								~(victim_clr ? (ENTRIES'(1) << best_idx_q) : ENTRIES'(0));
							key_q[slot]   <= key_in_q;
							val_q[slot]   <= val_in_q;
							cnt_q[slot]   <= UCNT_W'(1);
							use_q[slot]   <= time_q;
						end
					end
				end
				ST_DSCAN: idx_q <= idx_q + 1'b1;
				ST_DOUT:  if (best_ok_q) done_q[best_idx_q] <= 1'b1;
				ST_OUT:   idx_q <= '0;
				default:  ;
			endcase
		end
	end

	// input latch, scan accumulators and result register
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			func_q   <= func_t'(func);
			key_in_q <= key;
			val_in_q <= value;
		end
		if (state_q == ST_IDLE || state_q == ST_OUT) begin
			match_ok_q <= 1'b0;
			free_ok_q  <= 1'b0;
			best_ok_q  <= 1'b0;
			live_q     <= '0;
		end
		if (state_q == ST_SCAN) begin
			if (live_now) begin
				live_q <= live_q + 1'b1;
				if (!match_ok_q && key_q[idx_q] == key_in_q) begin
					match_ok_q  <= 1'b1;
					match_idx_q <= idx_q;
				end
				if (cr.evict_better) begin
					best_ok_q  <= 1'b1;
					best_idx_q <= idx_q;
					best_cnt_q <= cnt_q[idx_q];
					best_age_q <= cr.age;
				end
			end else if (!free_ok_q) begin
				free_ok_q  <= 1'b1;
				free_idx_q <= idx_q;
			end
		end
		if (state_q == ST_DSCAN && valid_q[idx_q] && !done_q[idx_q]) begin
			live_q <= live_q + 1'b1;
			if (cr.dump_better) begin
				best_ok_q  <= 1'b1;
				best_idx_q <= idx_q;
				best_age_q <= cr.age;
			end
		end
		if (state_q == ST_ACT) begin
			hit_q   <= match_ok_q;
			data_q  <= match_ok_q ? val_q[match_idx_q] : '1;
			last_q  <= 1'b1;
			empty_q <= 1'b0;
		end
		if (state_q == ST_DOUT) begin
			hit_q   <= best_ok_q;
			data_q  <= best_ok_q ? val_q[best_idx_q] : '1;
			last_q  <= live_q <= CNT_W'(1);
			empty_q <= !best_ok_q;
		end
	end
endmodule
